@@ sv/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// Particle state update package
// Shared types, constants and lookup functions for the particle update block.
// ----------------------------------------------------------------------------
package psu_pkg;

  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_GRAV     = 3'd1,
    KIND_SLOWGRAV = 3'd2,
    KIND_FIRE     = 3'd3,
    KIND_EXPLODE  = 3'd4,
    KIND_EXPLODE2 = 3'd5,
    KIND_BLOB     = 3'd6,
    KIND_BLOB2    = 3'd7
  } kind_t;

  localparam logic [1:0] CFG_NOW_TIME      = 2'd0;
  localparam logic [1:0] CFG_FRAME_TIME    = 2'd1;
  localparam logic [1:0] CFG_GRAVITY_ACCEL = 2'd2;

  localparam logic [11:0] GRAVITY_RESET = 12'd40;
  localparam logic [31:0] DEAD_MARK     = 32'h8000_0000;

  // vel * frame_time product, and the widest velocity sum before saturation
  localparam int PROD_W = 41;
  localparam int SUM_W  = 29;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(8388608);

  function automatic logic signed [23:0] sat24(input logic signed [SUM_W-1:0] x);
    logic signed [23:0] r;
    if (x > SAT_HI) begin
      r = 24'sh7f_ffff;
    end else if (x < SAT_LO) begin
      r = 24'sh80_0000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  // ramp rate per second, zero for kinds without a ramp
  function automatic logic [3:0] ramp_rate(input kind_t k);
    logic [3:0] r;
    unique case (k)
      KIND_FIRE:     r = 4'd5;
      KIND_EXPLODE:  r = 4'd10;
      KIND_EXPLODE2: r = 4'd15;
      default:       r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] ramp_limit(input kind_t k);
    return (k == KIND_FIRE) ? 4'd6 : 4'd8;
  endfunction

  function automatic logic [7:0] ramp_color(input kind_t k, input logic [2:0] idx);
    logic [7:0] c;
    if (k == KIND_EXPLODE) begin
      unique case (idx)
        3'd0: c = 8'h6f;
        3'd1: c = 8'h6d;
        3'd2: c = 8'h6b;
        3'd3: c = 8'h69;
        3'd4: c = 8'h67;
        3'd5: c = 8'h65;
        3'd6: c = 8'h63;
        default: c = 8'h61;
      endcase
    end else if (k == KIND_EXPLODE2) begin
      unique case (idx)
        3'd0: c = 8'h6f;
        3'd1: c = 8'h6e;
        3'd2: c = 8'h6d;
        3'd3: c = 8'h6c;
        3'd4: c = 8'h6b;
        3'd5: c = 8'h6a;
        3'd6: c = 8'h68;
        default: c = 8'h66;
      endcase
    end else begin
      unique case (idx)
        3'd0: c = 8'h6d;
        3'd1: c = 8'h6b;
        3'd2: c = 8'h06;
        3'd3: c = 8'h05;
        3'd4: c = 8'h04;
        3'd5: c = 8'h03;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

@@ sv/particle_state_update_top.sv @@
// ----------------------------------------------------------------------------
// Particle state update
// One frame step for one particle record per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one particle record per request.
//   Output channel (out_valid/out_ready) returns the updated record with keep.
//   Configuration (cfg_we/cfg_index/cfg_data) sets now_time, frame_time and
//   gravity_accel; write it only while no request is in flight.
//   Path: a request accepted enters the input register, then moves to the
//   result register once it can load, and is on the output from then on.
//   Throughput: one request per cycle while the output is not stalled, set by
//   the single multiply-add pass per axis between the two registers.
//   Stall: while out_ready is low the result register holds; if the input
//   register is empty one more request enters it, then in_ready drops.
//   Reset: both stages empty, now_time 0, frame_time 0, gravity_accel 40.
// ----------------------------------------------------------------------------
module particle_state_update_top import psu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [15:0]        ramp_in,
  input  logic [7:0]         color_in,
  input  logic signed [23:0] pos_x_in,
  input  logic signed [23:0] pos_y_in,
  input  logic signed [23:0] pos_z_in,
  input  logic signed [23:0] vel_x_in,
  input  logic signed [23:0] vel_y_in,
  input  logic signed [23:0] vel_z_in,
  input  logic signed [31:0] death_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               keep,
  output logic [2:0]         kind_out,
  output logic [15:0]        ramp_out,
  output logic [7:0]         color_out,
  output logic signed [23:0] pos_x_out,
  output logic signed [23:0] pos_y_out,
  output logic signed [23:0] pos_z_out,
  output logic signed [23:0] vel_x_out,
  output logic signed [23:0] vel_y_out,
  output logic signed [23:0] vel_z_out,
  output logic signed [31:0] death_out
);

  logic signed [31:0] now_time;
  logic [15:0]        frame_time;
  logic [11:0]        gravity_accel;

  logic               stage_valid;
  kind_t              stage_kind;
  logic [15:0]        stage_ramp;
  logic [7:0]         stage_color;
  logic signed [23:0] stage_pos [3];
  logic signed [23:0] stage_vel [3];
  logic signed [31:0] stage_death;

  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time      <= '0;
      frame_time    <= '0;
      gravity_accel <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOW_TIME:      now_time      <= cfg_data;
        CFG_FRAME_TIME:    frame_time    <= cfg_data[15:0];
        CFG_GRAVITY_ACCEL: gravity_accel <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign out_load = !out_valid || out_ready;
  assign in_ready = !stage_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_kind   <= kind_t'(kind);
      stage_ramp   <= ramp_in;
      stage_color  <= color_in;
      stage_pos[0] <= pos_x_in;
      stage_pos[1] <= pos_y_in;
      stage_pos[2] <= pos_z_in;
      stage_vel[0] <= vel_x_in;
      stage_vel[1] <= vel_y_in;
      stage_vel[2] <= vel_z_in;
      stage_death  <= death_in;
    end
  end

  // update datapath
  logic signed [16:0]       ft_s;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [PROD_W-1:0] prod_r16 [3];
  logic signed [PROD_W-1:0] prod_r14 [3];
  logic signed [SUM_W-1:0]  d16 [3];
  logic signed [SUM_W-1:0]  d14 [3];
  logic signed [SUM_W-1:0]  pos_sum [3];
  logic signed [SUM_W-1:0]  vel_sum [3];
  logic signed [SUM_W-1:0]  dv [3];
  logic [27:0]              g_prod;
  logic [27:0]              g_rnd;
  logic signed [SUM_W-1:0]  g_step;
  logic signed [SUM_W-1:0]  gz;
  logic [3:0]               rate;
  logic [19:0]              rate_prod;
  logic [19:0]              rate_rnd;
  logic [16:0]              ramp_sum;
  logic [15:0]              ramp_new;
  logic                     expired;
  logic                     ramp_end;

  logic               keep_next;
  logic [15:0]        ramp_next;
  logic [7:0]         color_next;
  logic signed [23:0] pos_next [3];
  logic signed [23:0] vel_next [3];
  logic signed [31:0] death_next;

  always_comb begin
    ft_s    = $signed({1'b0, frame_time});
    g_prod  = 28'(frame_time) * 28'(gravity_accel);
    g_rnd   = g_prod + 28'd128;
    g_step  = $signed(SUM_W'(g_rnd[27:8]));
    expired = stage_death < now_time;

    unique case (stage_kind)
      KIND_STATIC: gz = '0;
      KIND_FIRE:   gz = g_step;
      default:     gz = -g_step;
    endcase

    for (int i = 0; i < 3; i++) begin
      prod[i]     = PROD_W'(stage_vel[i]) * PROD_W'(ft_s);
      prod_r16[i] = (prod[i] + PROD_W'(32768)) >>> 16;
      prod_r14[i] = (prod[i] + PROD_W'(8192)) >>> 14;
      d16[i]      = prod_r16[i][SUM_W-1:0];
      d14[i]      = prod_r14[i][SUM_W-1:0];
      pos_sum[i]  = SUM_W'(stage_pos[i]) + d16[i];

      unique case (stage_kind)
        KIND_EXPLODE, KIND_BLOB: dv[i] = d14[i];
        KIND_EXPLODE2:           dv[i] = -d16[i];
        KIND_BLOB2:              dv[i] = (i == 2) ? '0 : -d14[i];
        default:                 dv[i] = '0;
      endcase
      vel_sum[i] = SUM_W'(stage_vel[i]) + dv[i] + ((i == 2) ? gz : '0);
    end

    rate      = ramp_rate(stage_kind);
    rate_prod = 20'(frame_time) * 20'(rate);
    rate_rnd  = rate_prod + 20'd8;
    ramp_sum  = {1'b0, stage_ramp} + {1'b0, rate_rnd[19:4]};
    ramp_new  = ramp_sum[16] ? 16'hffff : ramp_sum[15:0];
    ramp_end  = ramp_new[15:12] >= ramp_limit(stage_kind);

    keep_next  = !expired;
    ramp_next  = stage_ramp;
    color_next = stage_color;
    death_next = stage_death;
    for (int i = 0; i < 3; i++) begin
      pos_next[i] = stage_pos[i];
      vel_next[i] = stage_vel[i];
    end

    if (!expired) begin
      for (int i = 0; i < 3; i++) begin
        pos_next[i] = sat24(pos_sum[i]);
        vel_next[i] = sat24(vel_sum[i]);
      end
      if (rate != 4'd0) begin
        ramp_next = ramp_new;
        if (ramp_end) begin
          death_next = DEAD_MARK;
        end else begin
          color_next = ramp_color(stage_kind, ramp_new[14:12]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      keep      <= keep_next;
      kind_out  <= stage_kind;
      ramp_out  <= ramp_next;
      color_out <= color_next;
      pos_x_out <= pos_next[0];
      pos_y_out <= pos_next[1];
      pos_z_out <= pos_next[2];
      vel_x_out <= vel_next[0];
      vel_y_out <= vel_next[1];
      vel_z_out <= vel_next[2];
      death_out <= death_next;
    end
  end

endmodule

@@ sv/psu_checker.sv @@
// ----------------------------------------------------------------------------
// Particle state update checker
// Port-level timing checks on the particle update block, bound to the top.
// ----------------------------------------------------------------------------
module psu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               keep,
  input logic signed [23:0] pos_x_out,
  input logic signed [31:0] death_out
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request two cycles earlier");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(keep) && $stable(pos_x_out) && $stable(death_out))
    else $error("stalled result changed");

endmodule

bind particle_state_update_top psu_checker u_psu_checker (.*);

@@ verif/particle_state_update_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle state update testbench
// Drives particle records through particle_state_update_top under random
// idling and a long output stall, predicts each updated record from its own
// fixed-point model of one frame step, and checks every field of every result.
// ----------------------------------------------------------------------------
module testbench;
  import psu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  localparam logic [0:7][7:0] FIRE_COLORS =
    {8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03, 8'h00, 8'h00};
  localparam logic [0:7][7:0] EXPLODE_COLORS =
    {8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
  localparam logic [0:7][7:0] EXPLODE2_COLORS =
    {8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

  typedef struct packed {
    kind_t            kind;
    logic [15:0]      ramp;
    logic [7:0]       color;
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [31:0]      death;
  } psu_item_t;

  typedef struct packed {
    logic             keep;
    kind_t            kind;
    logic [15:0]      ramp;
    logic [7:0]       color;
    logic [2:0][23:0] pos;
    logic [2:0][23:0] vel;
    logic [31:0]      death;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_NOW_TIME;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = '0;
  logic [15:0] ramp_in = '0;
  logic [7:0] color_in = '0;
  logic signed [23:0] pos_x_in = '0;
  logic signed [23:0] pos_y_in = '0;
  logic signed [23:0] pos_z_in = '0;
  logic signed [23:0] vel_x_in = '0;
  logic signed [23:0] vel_y_in = '0;
  logic signed [23:0] vel_z_in = '0;
  logic signed [31:0] death_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic keep;
  logic [2:0] kind_out;
  logic [15:0] ramp_out;
  logic [7:0] color_out;
  logic signed [23:0] pos_x_out;
  logic signed [23:0] pos_y_out;
  logic signed [23:0] pos_z_out;
  logic signed [23:0] vel_x_out;
  logic signed [23:0] vel_y_out;
  logic signed [23:0] vel_z_out;
  logic signed [31:0] death_out;

  // shadow copies of the frame registers
  logic signed [31:0] cur_now = '0;
  logic [15:0] cur_frame_time = '0;
  logic [11:0] cur_gravity = GRAVITY_RESET;

  update_t expected_updates[$];
  int mismatch_count = 0;
  int cycles_run = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic long_hold = 1'b0;
  event long_hold_go;

  particle_state_update_top u_top (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic longint round_shift(input longint x, input int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [23:0] clamp24(input longint x);
    if (x > 64'sd8388607) begin
      return 24'h7f_ffff;
    end else if (x < -64'sd8388608) begin
      return 24'h80_0000;
    end
    return x[23:0];
  endfunction

  function automatic update_t predict_update(input psu_item_t p);
    update_t r;
    longint ft;
    longint g;
    longint nv [3];
    int unsigned rate;
    int unsigned limit;
    int unsigned ramp_sum;
    logic [0:7][7:0] colors;
    int i;
    r.keep = 1'b1;
    r.kind = p.kind;
    r.ramp = p.ramp;
    r.color = p.color;
    r.pos = p.pos;
    r.vel = p.vel;
    r.death = p.death;
    if ($signed(p.death) < cur_now) begin
      r.keep = 1'b0;
      return r;
    end
    ft = longint'(cur_frame_time);
    g = round_shift(ft * longint'(cur_gravity), 8);
    for (i = 0; i < 3; i++) begin
      nv[i] = longint'($signed(p.vel[i]));
      r.pos[i] = clamp24(longint'($signed(p.pos[i])) + round_shift(nv[i] * ft, 16));
    end

    rate = 0;
    limit = 0;
    colors = FIRE_COLORS;
    case (p.kind)
      KIND_FIRE: begin
        rate = 5;
        limit = 6;
      end
      KIND_EXPLODE: begin
        rate = 10;
        limit = 8;
        colors = EXPLODE_COLORS;
      end
      KIND_EXPLODE2: begin
        rate = 15;
        limit = 8;
        colors = EXPLODE2_COLORS;
      end
      default: ;
    endcase
    if (rate != 0) begin
      ramp_sum = 32'(p.ramp) + ((32'(cur_frame_time) * rate + 32'd8) >> 4);
      if (ramp_sum > 32'hffff) begin
        ramp_sum = 32'hffff;
      end
      r.ramp = ramp_sum[15:0];
      if ((ramp_sum >> 12) >= limit) begin
        r.death = DEAD_MARK;
      end else begin
        r.color = colors[ramp_sum[14:12]];
      end
    end

    case (p.kind)
      KIND_GRAV, KIND_SLOWGRAV: nv[2] -= g;
      KIND_FIRE: nv[2] += g;
      KIND_EXPLODE, KIND_BLOB: begin
        for (i = 0; i < 3; i++) nv[i] += round_shift(nv[i] * ft, 14);
        nv[2] -= g;
      end
      KIND_EXPLODE2: begin
        for (i = 0; i < 3; i++) nv[i] -= round_shift(nv[i] * ft, 16);
        nv[2] -= g;
      end
      KIND_BLOB2: begin
        for (i = 0; i < 2; i++) nv[i] -= round_shift(nv[i] * ft, 14);
        nv[2] -= g;
      end
      default: ;
    endcase
    for (i = 0; i < 3; i++) r.vel[i] = clamp24(nv[i]);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic psu_item_t make_particle(
    input kind_t k, input logic [15:0] ramp, input logic [7:0] color,
    input logic [23:0] px, input logic [23:0] py, input logic [23:0] pz,
    input logic [23:0] vx, input logic [23:0] vy, input logic [23:0] vz,
    input logic [31:0] death);
    psu_item_t p;
    p.kind = k;
    p.ramp = ramp;
    p.color = color;
    p.pos = {pz, py, px};
    p.vel = {vz, vy, vx};
    p.death = death;
    return p;
  endfunction

  function automatic logic [23:0] random_q15_8();
    int v;
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 24'h7f_ffff : 24'h80_0000;
      1, 2, 3: return 24'($urandom);
      default: begin
        v = int'($urandom_range(16383)) - 8192;
        return 24'(v);
      end
    endcase
  endfunction

  function automatic psu_item_t random_particle();
    psu_item_t p;
    longint d;
    int i;
    p.kind = kind_t'($urandom_range(7));
    p.ramp = $urandom_range(1) ? 16'($urandom_range(16'h8fff)) : 16'($urandom);
    p.color = 8'($urandom);
    for (i = 0; i < 3; i++) begin
      p.pos[i] = random_q15_8();
      p.vel[i] = random_q15_8();
    end
    if ($urandom_range(4) == 0) begin
      p.death = $urandom;
    end else begin
      d = longint'(cur_now) + longint'($urandom_range(32'h7_ffff));
      if (d > 64'sd2147483647) begin
        d = 64'sd2147483647;
      end
      p.death = d[31:0];
    end
    return p;
  endfunction

  task automatic send_particle(input psu_item_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= p.kind;
    ramp_in <= p.ramp;
    color_in <= p.color;
    pos_x_in <= p.pos[0];
    pos_y_in <= p.pos[1];
    pos_z_in <= p.pos[2];
    vel_x_in <= p.vel[0];
    vel_y_in <= p.vel[1];
    vel_z_in <= p.vel[2];
    death_in <= p.death;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_updates.push_back(predict_update(p));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_frame(input logic [31:0] now, input logic [15:0] ft,
                            input logic [11:0] grav);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NOW_TIME;
    cfg_data <= now;
    @(posedge clk);
    cfg_index <= CFG_FRAME_TIME;
    cfg_data <= {16'h0, ft};
    @(posedge clk);
    cfg_index <= CFG_GRAVITY_ACCEL;
    cfg_data <= {20'h0, grav};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_now = now;
    cur_frame_time = ft;
    cur_gravity = grav;
  endtask

  task automatic random_frame();
    logic [31:0] now;
    logic [15:0] ft;
    logic [11:0] grav;
    now = $urandom_range(3) == 0 ? 32'h0 : $urandom;
    case ($urandom_range(3))
      0: ft = 16'h0000;
      1: ft = 16'hffff;
      2: ft = 16'($urandom);
      default: ft = 16'($urandom_range(3000, 500));
    endcase
    case ($urandom_range(2))
      0: grav = 12'h000;
      1: grav = 12'hfff;
      default: grav = 12'($urandom);
    endcase
    load_frame(now, ft, grav);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_each_kind();
    int k;
    load_frame(32'h0001_0000, 16'd1092, 12'd40);
    for (k = 0; k < 8; k++) begin
      send_particle(make_particle(kind_t'(k), 16'h1800, 8'h20, 24'd2560, -24'd1280,
                                  24'd25600, 24'd12800, -24'd6400, 24'd3200,
                                  32'h0002_0000));
    end
    drain_pipeline();
  endtask

  task automatic test_expiry();
    send_particle(make_particle(KIND_GRAV, 16'h0100, 8'h44, 24'd100, 24'd200, 24'd300,
                                24'd400, 24'd500, 24'd600, 32'h0000_ffff));
    send_particle(make_particle(KIND_FIRE, 16'h0100, 8'h44, 24'd100, 24'd200, 24'd300,
                                24'd400, 24'd500, 24'd600, 32'h0001_0000));
    drain_pipeline();
  endtask

  task automatic test_ramp_end();
    send_particle(make_particle(KIND_FIRE, 16'h5f00, 8'h11, 24'd0, 24'd0, 24'd0,
                                24'd256, 24'd256, 24'd256, 32'h0003_0000));
    send_particle(make_particle(KIND_FIRE, 16'h5000, 8'h11, 24'd0, 24'd0, 24'd0,
                                24'd256, 24'd256, 24'd256, 32'h0003_0000));
    send_particle(make_particle(KIND_EXPLODE, 16'h7e00, 8'h11, 24'd0, 24'd0, 24'd0,
                                24'd256, 24'd256, 24'd256, 32'h0003_0000));
    send_particle(make_particle(KIND_EXPLODE2, 16'hfff0, 8'h11, 24'd0, 24'd0, 24'd0,
                                24'd256, 24'd256, 24'd256, 32'h0003_0000));
    send_particle(make_particle(KIND_EXPLODE2, 16'h0000, 8'h11, 24'd0, 24'd0, 24'd0,
                                24'd256, 24'd256, 24'd256, 32'h0003_0000));
    drain_pipeline();
  endtask

  task automatic test_field_extremes();
    load_frame(32'h8000_0000, 16'hffff, 12'hfff);
    send_particle(make_particle(KIND_STATIC, 16'hffff, 8'hff, 24'h7f_ffff, 24'h7f_ffff,
                                24'h7f_ffff, 24'h7f_ffff, 24'h7f_ffff, 24'h7f_ffff,
                                32'h8000_0000));
    send_particle(make_particle(KIND_GRAV, 16'h0000, 8'h00, 24'h80_0000, 24'h80_0000,
                                24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000,
                                32'h7fff_ffff));
    send_particle(make_particle(KIND_BLOB, 16'h0000, 8'h00, 24'h00_0000, 24'h7f_ffff,
                                24'h80_0000, 24'h7f_ffff, 24'h7f_ffff, 24'h7f_ffff,
                                32'h0000_0000));
    send_particle(make_particle(KIND_BLOB2, 16'h0000, 8'h00, 24'h7f_ffff, 24'h80_0000,
                                24'h00_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000,
                                32'hffff_ffff));
    send_particle(make_particle(KIND_EXPLODE2, 16'h0000, 8'h00, 24'h80_0000, 24'h7f_ffff,
                                24'h00_0001, 24'h7f_ffff, 24'h80_0000, 24'h7f_ffff,
                                32'h0000_0001));
    send_particle(make_particle(KIND_FIRE, 16'h0000, 8'hff, 24'h00_0000, 24'h00_0000,
                                24'h00_0000, 24'h80_0000, 24'h7f_ffff, 24'h80_0000,
                                32'h1234_5678));
    drain_pipeline();
    load_frame(32'h7fff_ffff, 16'hffff, 12'hfff);
    send_particle(make_particle(KIND_EXPLODE, 16'hffff, 8'hff, 24'h7f_ffff, 24'h80_0000,
                                24'h7f_ffff, 24'h80_0000, 24'h7f_ffff, 24'h80_0000,
                                32'h7fff_fffe));
    send_particle(make_particle(KIND_EXPLODE, 16'h0000, 8'h00, 24'h80_0000, 24'h7f_ffff,
                                24'h80_0000, 24'h7f_ffff, 24'h80_0000, 24'h7f_ffff,
                                32'h7fff_ffff));
    drain_pipeline();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        drain_pipeline();
        random_frame();
      end
      send_particle(random_particle());
    end
    drain_pipeline();
  endtask

  // output held off while requests keep coming, so the input side must stall
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frame();
    -> long_hold_go;
    for (k = 0; k < 30; k++) send_particle(random_particle());
    drain_pipeline();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    out_ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(long_hold_go);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic check_field(input string field_name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name,
               want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    update_t got;
    update_t want;
    if (!rst && out_valid && out_ready) begin
      got.keep = keep;
      got.kind = kind_t'(kind_out);
      got.ramp = ramp_out;
      got.color = color_out;
      got.pos = {pos_z_out, pos_y_out, pos_x_out};
      got.vel = {vel_z_out, vel_y_out, vel_x_out};
      got.death = death_out;
      if (expected_updates.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual keep %b kind %0d",
                 $time, got.keep, got.kind);
      end else begin
        want = expected_updates.pop_front();
        check_field("keep", 32'(want.keep), 32'(got.keep));
        check_field("kind_out", 32'(want.kind), 32'(got.kind));
        check_field("ramp_out", 32'(want.ramp), 32'(got.ramp));
        check_field("color_out", 32'(want.color), 32'(got.color));
        check_field("pos_x_out", 32'(want.pos[0]), 32'(got.pos[0]));
        check_field("pos_y_out", 32'(want.pos[1]), 32'(got.pos[1]));
        check_field("pos_z_out", 32'(want.pos[2]), 32'(got.pos[2]));
        check_field("vel_x_out", 32'(want.vel[0]), 32'(got.vel[0]));
        check_field("vel_y_out", 32'(want.vel[1]), 32'(got.vel[1]));
        check_field("vel_z_out", 32'(want.vel[2]), 32'(got.vel[2]));
        check_field("death_out", want.death, got.death);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("FAIL particle_state_update_top");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_each_kind();
    test_expiry();
    test_ramp_end();
    test_field_extremes();
    test_random_traffic(13, 88, 170);
    test_random_traffic(88, 13, 170);
    test_random_traffic(0, 0, 170);
    test_backpressure();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("PASS particle_state_update_top");
    end else begin
      $display("FAIL particle_state_update_top");
    end
    $finish;
  end

endmodule
